[src/srit_pkg.sv]
// Shared types, codes and constants for the sorted record insert table.
package srit_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int KEY_W        = 16;
  localparam int SCORE_W      = 10;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [KEY_W-1:0]   rec_key;
    logic [SCORE_W-1:0] rec_score;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0]   out_key;
    logic [SCORE_W-1:0] out_score;
    logic [1:0]         status;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } rec_t;

  typedef struct packed {
    logic ins_en;
    logic rot_en;
    logic sorted;
    rec_t new_rec;
  } cell_ctrl_t;

endpackage

[src/srit_cell.sv]
// One table cell: holds a record, shifts right on insert, rotates left on dump.
module srit_cell (
  input  logic                   clk,
  input  srit_pkg::cell_ctrl_t   ctrl,
  input  logic                   occupied,
  input  logic                   hit_in,
  output logic                   hit_out,
  input  srit_pkg::rec_t         left_rec,
  input  srit_pkg::rec_t         right_rec,
  output srit_pkg::rec_t         rec
);
  import srit_pkg::*;

  logic ge;

  // free cells always match, so the first free cell is the tail slot
  assign ge      = occupied ? (ctrl.sorted && (rec.key >= ctrl.new_rec.key)) : 1'b1;
  assign hit_out = hit_in | ge;

  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (hit_in) begin
        rec <= left_rec;
      end else if (ge) begin
        rec <= ctrl.new_rec;
      end
    end else if (ctrl.rot_en) begin
      rec <= right_rec;
    end
  end

endmodule

[src/sorted_record_insert_table_unit.sv]
// Top level of the sorted record insert table: cell chain, count and dump sequencer.
//
//   channel  | signals                     | payload
//   req      | req_valid, req_ready, req   | func, rec_key, rec_score
//   rsp      | rsp_valid, rsp_ready, rsp   | out_key, out_score, status, last
//
// Append and insert write on acceptance: every cell compares against the new key
// at once and the cells at and past the slot shift right together.
// Dump rotates the whole chain left CAPACITY times, showing the
// head cell for the first min(count, 16) steps, so the table ends where it began.
// A dump of an empty table answers with the empty status and skips the dump state.
// A dump step that shows an entry waits while the response register is held.
// Synchronous reset empties the table; cell contents are not cleared.
module sorted_record_insert_table_unit #(
  parameter int CAPACITY = srit_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  srit_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output srit_pkg::rsp_t rsp
);
  import srit_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY);
  localparam int NW = (CW > 5) ? CW : 5;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic [0:0]    state;
  logic [CW-1:0] count;
  logic [SW-1:0] step;

  cell_ctrl_t    ctrl;
  rec_t          recs [CAPACITY];
  logic          hit  [CAPACITY+1];

  logic          out_free;
  logic          acc;
  logic          is_write;
  logic          full;
  logic          op_done;
  logic [NW-1:0] n_show;
  logic          dump_show;
  logic          dump_adv;
  logic          step_end;
  logic          dump_last;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE) && out_free;
  assign acc       = req_valid && req_ready;
  assign full      = (count == CW'(CAPACITY));

  always_comb begin
    is_write = req.func inside {FUNC_APPEND, FUNC_INSERT};
  end

  // single-result transactions: append, insert, dump of an empty table
  assign op_done   = acc && (is_write || ((req.func == FUNC_DUMP) && (count == '0)));

  assign n_show    = (NW'(count) > NW'(MAX_RESULTS)) ? NW'(MAX_RESULTS) : NW'(count);
  assign dump_show = (state == ST_DUMP) && (NW'(step) < n_show);
  assign dump_adv  = (state == ST_DUMP) && (!dump_show || out_free);
  assign step_end  = (step == SW'(CAPACITY - 1));
  assign dump_last = ((NW'(step) + NW'(1)) == n_show);

  assign ctrl.ins_en        = acc && is_write && !full;
  assign ctrl.rot_en        = dump_adv;
  assign ctrl.sorted        = (req.func == FUNC_INSERT);
  assign ctrl.new_rec.key   = req.rec_key;
  assign ctrl.new_rec.score = req.rec_score;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    srit_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (CW'(i) < count),
      .hit_in   (hit[i]),
      .hit_out  (hit[i+1]),
      .left_rec ((i == 0) ? ctrl.new_rec : recs[(i == 0) ? 0 : i - 1]),
      .right_rec(recs[(i + 1) % CAPACITY]),
      .rec      (recs[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      step  <= '0;
    end else begin
      if (ctrl.ins_en) begin
        count <= count + CW'(1);
      end
      case (state)
        ST_IDLE: begin
          if (acc && (req.func == FUNC_DUMP) && (count != '0)) begin
            state <= ST_DUMP;
            step  <= '0;
          end
        end
        ST_DUMP: begin
          if (dump_adv) begin
            step <= step + SW'(1);
            if (step_end) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (op_done || (dump_adv && dump_show)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dump_adv && dump_show) begin
      rsp.out_key   <= recs[0].key;
      rsp.out_score <= recs[0].score;
      rsp.status    <= STATUS_OK;
      rsp.last      <= dump_last;
    end else if (op_done) begin
      rsp.out_key   <= '0;
      rsp.out_score <= '0;
      rsp.last      <= 1'b1;
      if (is_write) begin
        rsp.status <= full ? STATUS_FULL : STATUS_OK;
      end else begin
        rsp.status <= STATUS_EMPTY;
      end
    end
  end

endmodule
